// ===== src/u2c_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the code point to Windows-1251 mapping function.
package u2c_pkg;

    // One decoded character or a terminator, passed from the front end to the mapper.
    typedef struct packed {
        logic        term;   // string terminator
        logic        multi;  // code point came from a multi-byte sequence
        logic [15:0] cp;     // decoded code point
        logic [7:0]  b2;     // first continuation byte, selects the Latin-1 keep bit
    } u2c_entry_t;

    // Sequence length codes: continuation bytes still expected after the lead.
    localparam logic [1:0] SEQ_ONE   = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    localparam logic [31:0] LATIN_KEEP_MASK = 32'hF71C_852E;
    localparam logic [15:0] CYR_OFFSET      = 16'h0350;

    localparam logic [7:0] CYR_UPPER [16] = '{
        8'h00, 8'hA8, 8'h80, 8'h81, 8'hAA, 8'hBD, 8'hB2, 8'hAF,
        8'hA3, 8'h8A, 8'h8C, 8'h8E, 8'h8D, 8'h00, 8'hA1, 8'h8F
    };
    localparam logic [7:0] CYR_LOWER [16] = '{
        8'h00, 8'hB8, 8'h90, 8'h83, 8'hBA, 8'hBE, 8'hB3, 8'hBF,
        8'hBC, 8'h9A, 8'h9C, 8'h9E, 8'h9D, 8'h00, 8'hA2, 8'h9F
    };
    localparam logic [7:0] CYR_PUNCT [16] = '{
        8'h86, 8'h87, 8'h95, 8'h96, 8'h97, 8'h00, 8'h00, 8'h00,
        8'h91, 8'h92, 8'h82, 8'h00, 8'h93, 8'h94, 8'h84, 8'h00
    };

    // Continuation bytes that follow a lead byte.
    function automatic logic [1:0] seq_extra(input logic [7:0] lead);
        logic [1:0] r;
        priority if (lead[7:4] == 4'hF)
            r = SEQ_FOUR;
        else if (lead[7:4] == 4'hE)
            r = SEQ_THREE;
        else if (lead[7:6] == 2'b11)
            r = SEQ_TWO;
        else
            r = SEQ_ONE;
        return r;
    endfunction

    // Map a code point to one Windows-1251 byte; zero means no mapping.
    function automatic logic [7:0] map_cp(input logic [15:0] p, input logic [7:0] b2,
                                          input logic multi);
        logic [15:0] d;
        logic [7:0]  r;
        d = p - CYR_OFFSET;
        priority if (!multi)
            r = p[7:0];
        else if (p[15:5] == 11'h005 && !LATIN_KEEP_MASK[b2[4:0]])
            r = p[7:0];
        else if (p >= 16'h0410 && p <= 16'h044F)
            r = d[7:0];
        else if (p[15:4] == 12'h040)
            r = CYR_UPPER[p[3:0]];
        else if (p[15:4] == 12'h045)
            r = CYR_LOWER[p[3:0]];
        else if (p >= 16'h2013 && p <= 16'h2022)
            r = CYR_PUNCT[p[3:0]];
        else
        begin
            unique case (p)
                16'h0490: r = 8'hA5;
                16'h0491: r = 8'hB4;
                16'h2026: r = 8'h85;
                16'h2030: r = 8'h89;
                16'h2039: r = 8'h8B;
                16'h203A: r = 8'h9B;
                16'h20AC: r = 8'h88;
                16'h2116: r = 8'hB9;
                16'h2122: r = 8'h99;
                default:  r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== src/u2c_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts UTF-8 bytes, assembles sequences and queues decoded code points.
module u2c_front
    import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       push,
    output u2c_entry_t push_entry
);

    logic [1:0] pend_reg, pend_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] sec_reg,  sec_next;
    logic       take;
    logic [1:0] extra_in;
    logic [1:0] extra_lead;

    assign in_ready   = !q_full;
    assign take       = in_valid && in_ready;
    assign extra_in   = seq_extra(in_byte);
    assign extra_lead = seq_extra(lead_reg);

    always_comb
    begin
        pend_next  = pend_reg;
        lead_next  = lead_reg;
        sec_next   = sec_reg;
        push       = 1'b0;
        push_entry = '0;
        if (take)
        begin
            priority if (in_byte == 8'h00)
            begin
                // terminator: drop any pending character
                push            = 1'b1;
                push_entry.term = 1'b1;
                pend_next       = '0;
                lead_next       = '0;
                sec_next        = '0;
            end
            else if (pend_reg == 2'd0)
            begin
                lead_next = in_byte;
                if (extra_in != SEQ_ONE)
                    pend_next = extra_in;
                else if (!in_byte[7])
                begin
                    push          = 1'b1;
                    push_entry.cp = {8'h00, in_byte};
                end
            end
            else if (pend_reg >= 2'd2)
            begin
                sec_next  = in_byte;
                pend_next = pend_reg - 2'd1;
            end
            else
            begin
                pend_next = '0;
                unique case (extra_lead)
                    SEQ_TWO:
                    begin
                        push             = 1'b1;
                        push_entry.multi = 1'b1;
                        push_entry.cp    = {5'd0, lead_reg[4:0], in_byte[5:0]};
                        push_entry.b2    = in_byte;
                    end
                    SEQ_THREE:
                    begin
                        push             = 1'b1;
                        push_entry.multi = 1'b1;
                        push_entry.cp    = {lead_reg[3:0], sec_reg[5:0], in_byte[5:0]};
                        push_entry.b2    = sec_reg;
                    end
                    default: ; // four-byte sequence: drop
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            lead_reg <= '0;
            sec_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            lead_reg <= lead_next;
            sec_reg  <= sec_next;
        end
    end

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_byte == 8'h00 |=> pend_reg == 2'd0)
        else $error("pending sequence not cleared by terminator");

endmodule

// ===== src/u2c_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front end and the mapper.
module u2c_fifo
    import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u2c_entry_t push_entry,
    input  logic       pop,
    output u2c_entry_t head,
    output logic       empty,
    output logic       full
);

    u2c_entry_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] fill_reg;

    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'd2);
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// ===== src/u2c_back.sv =====
`timescale 1ns / 1ps
// Back end: maps queued code points, counts characters and holds the output register.
module u2c_back
    import u2c_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  u2c_entry_t head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       end_of_string,
    output logic [15:0] char_count
);

    localparam int WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WideBits-1:0]   cnt_wide;
    logic [15:0]           cnt_sat;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  eos_reg, eos_next;
    logic [15:0]           count_reg, count_next;
    logic [7:0]            code;
    logic                  load;

    assign cnt_wide = WideBits'(cnt_reg);
    assign cnt_sat  = (cnt_wide > WideBits'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];
    assign code     = map_cp(head.cp, head.b2, head.multi);
    assign pop      = !empty && (!valid_reg || out_ready);
    assign load     = pop && (head.term || code != 8'h00);

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        eos_next   = eos_reg;
        count_next = count_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (head.term)
            begin
                byte_next  = 8'h00;
                eos_next   = 1'b1;
                count_next = cnt_sat;
                cnt_next   = '0;
            end
            else
            begin
                byte_next  = code;
                eos_next   = 1'b0;
                count_next = '0;
                if (cnt_reg != '1)
                    cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        eos_reg   <= eos_next;
        count_reg <= count_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign end_of_string = eos_reg;
    assign char_count    = count_reg;

    a_term_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        load && head.term |=> cnt_reg == '0)
        else $error("count not cleared after terminator");
    a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !eos_reg |-> byte_reg != 8'h00 && count_reg == 16'h0000)
        else $error("character result with zero code or nonzero count");

endmodule

// ===== src/utf8_to_cp1251_stream_top.sv =====
`timescale 1ns / 1ps
// UTF-8 to Windows-1251 stream converter, top level.
// Throughput: one input byte per cycle while out_ready stays high; the queue moves one item
//   per cycle each way. A byte that completes a character or ends the string is written
//   into the queue when accepted, then mapped into the output register when the back end
//   pops it, which waits while a held result is not yet taken.
// Bytes that only start or continue a sequence, and unmappable characters, produce no item.
// Reset (rst_n, asynchronous, active low) clears the sequence state, the queue,
//   the character count and the output valid flag; no clearing pass is needed.
module utf8_to_cp1251_stream_top
    import u2c_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        end_of_string,
    output logic [15:0] char_count
);

    // Front end to queue: one decoded character or terminator per push.
    logic       push;
    u2c_entry_t push_entry;
    logic       q_full;

    // Queue to back end.
    u2c_entry_t head;
    logic       q_empty;
    logic       pop;

    // Assemble UTF-8 sequences; stall input only when the queue is full.
    u2c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the decoder from output backpressure.
    u2c_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Map code points, drop unmapped ones, count and emit the terminator.
    u2c_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .char_count    (char_count)
    );

endmodule
